// File: hw/rtl/sequential_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Shared helpers for the concurrent checks in the list engine module.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define SLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Plain invariant.
`define SLE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

// File: hw/rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Opcodes, status codes, field widths and the cell command type.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int OPCODE_W   = 3;
   localparam int POSITION_W = 5;
   localparam int WORD_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_ERASE      = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_READ       = 3'd6;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // Broadcast to every cell: open a slot or close one at the given position.
   typedef struct packed {
      logic open_slot;
      logic close_slot;
   } cell_cmd_type;

endpackage

// File: hw/rtl/sle_cell.sv
// ----------------------------------------------------------------------------
// Sequential list engine cell
// Holds one list entry and moves it to or from its neighbours on a command.
// ----------------------------------------------------------------------------
module sle_cell #(
   parameter int INDEX = 0,
   parameter int POS_W = 5
) (
   input  logic                        clock,
   input  sle_pkg::cell_cmd_type       cmd,
   input  logic [POS_W-1:0]            pos,
   input  logic signed [31:0]          new_word,
   input  logic signed [31:0]          left_word,
   input  logic signed [31:0]          right_word,
   output logic signed [31:0]          entry_word,
   output logic signed [31:0]          read_word
);
   import sle_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic signed [WORD_W-1:0] entry_ff;
   logic signed [WORD_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.open_slot) begin
         if (MY_POS == pos) begin
            entry_in = new_word;
         end else if (MY_POS > pos) begin
            entry_in = left_word;
         end
      end else if (cmd.close_slot) begin
         if (MY_POS >= pos) begin
            entry_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_word = entry_ff;
   // Only the addressed cell drives a non-zero word onto the read OR tree.
   assign read_word  = (MY_POS == pos) ? entry_ff : '0;

endmodule

// File: hw/rtl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// Sequential list engine
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// req_     in         req_tvalid/req_tready   opcode, position, value
// rsp_     out        rsp_tvalid/rsp_tready   status, count, read_value
//
// One request is taken per cycle; moving cells shift in the same cycle as the
// request is accepted, so the rate is set by the single decode and shift step.
// The response is in the output register in the cycle after acceptance.
// The input stalls only while that output register holds an untaken response.
// Synchronous reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] opcode, [7:3] position, [39:8] value
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [6:2] count, [38:7] read_value, [39] zero
   output logic [39:0] rsp_tdata
);
   import sle_pkg::*;

`include "sequential_list_engine_defines.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
   localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

   logic [OPCODE_W-1:0]      req_opcode;
   logic [POSITION_W-1:0]    req_position;
   logic signed [WORD_W-1:0] req_value;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [STATUS_W-1:0]      rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic [COUNT_W-1:0]       rsp_count_in;
   logic signed [WORD_W-1:0] rsp_word_ff;
   logic signed [WORD_W-1:0] rsp_word_in;

   logic                     req_accept;
   logic [POS_W-1:0]         pos_ext;
   logic [POS_W-1:0]         count_ext;
   logic [POS_W-1:0]         count_next_ext;
   logic                     list_full;
   logic                     list_empty;
   cell_cmd_type             cmd;
   cell_cmd_type             cell_cmd;
   logic [POS_W-1:0]         cmd_pos;
   logic [STATUS_W-1:0]      status;
   logic                     count_up;
   logic                     count_down;
   logic signed [WORD_W-1:0] read_word;

   logic signed [WORD_W-1:0] entry_word [CAPACITY];
   logic signed [WORD_W-1:0] cell_read  [CAPACITY];

   assign req_opcode   = req_tdata[2:0];
   assign req_position = req_tdata[7:3];
   assign req_value    = req_tdata[39:8];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign pos_ext    = POS_W'(req_position);
   assign count_ext  = POS_W'(count_ff);
   assign list_full  = (count_ext == CAP_POS);
   assign list_empty = (count_ff == '0);

   always_comb begin
      cmd        = '0;
      cmd_pos    = pos_ext;
      status     = ST_DONE;
      count_up   = 1'b0;
      count_down = 1'b0;
      unique case (req_opcode)
         OP_PUSH_BACK: begin
            if (list_full) begin
               status = ST_FULL;
            end else begin
               cmd.open_slot = 1'b1;
               cmd_pos       = count_ext;
               count_up      = 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (list_full) begin
               status = ST_FULL;
            end else begin
               cmd.open_slot = 1'b1;
               cmd_pos       = '0;
               count_up      = 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (list_empty) begin
               status = ST_EMPTY;
            end else begin
               count_down = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (list_empty) begin
               status = ST_EMPTY;
            end else begin
               cmd.close_slot = 1'b1;
               cmd_pos        = '0;
               count_down     = 1'b1;
            end
         end
         OP_INSERT: begin
            if (list_full) begin
               status = ST_FULL;
            end else if (pos_ext > count_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.open_slot = 1'b1;
               count_up      = 1'b1;
            end
         end
         OP_ERASE: begin
            if (list_empty) begin
               status = ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               status = ST_RANGE;
            end else begin
               cmd.close_slot = 1'b1;
               count_down     = 1'b1;
            end
         end
         OP_READ: begin
            if (list_empty) begin
               status = ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   assign cell_cmd.open_slot  = cmd.open_slot && req_accept;
   assign cell_cmd.close_slot = cmd.close_slot && req_accept;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic signed [WORD_W-1:0] left_word;
         logic signed [WORD_W-1:0] right_word;
         if (g == 0) begin : g_first
            assign left_word = '0;
         end else begin : g_mid_l
            assign left_word = entry_word[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_word = '0;
         end else begin : g_mid_r
            assign right_word = entry_word[g+1];
         end
         sle_cell #(
            .INDEX (g),
            .POS_W (POS_W)
         ) u_cell (
            .clock      (clock),
            .cmd        (cell_cmd),
            .pos        (cmd_pos),
            .new_word   (req_value),
            .left_word  (left_word),
            .right_word (right_word),
            .entry_word (entry_word[g]),
            .read_word  (cell_read[g])
         );
      end
   endgenerate

   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_read[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_accept && count_up) begin
         count_in = count_ff + CNT_W'(1);
      end else if (req_accept && count_down) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_next_ext = POS_W'(count_in);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_word_in   = rsp_word_ff;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_count_in  = count_next_ext[COUNT_W-1:0];
         rsp_word_in   = (req_opcode == OP_READ && status == ST_DONE) ? read_word : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_word_ff, rsp_count_ff, rsp_status_ff};

   `SLE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ext <= CAP_POS, "count above capacity")
   `SLE_ASSERT_NEXT(a_reject_keeps_count, clock, reset, req_accept && status != ST_DONE, count_ff == $past(count_ff), "rejected request changed count")
   `SLE_ASSERT_NEXT(a_grow_by_one, clock, reset, req_accept && cmd.open_slot, count_ff == $past(count_ff) + CNT_W'(1), "slot opened without count growth")
   `SLE_ASSERT_IMP(a_reject_zero_word, clock, reset, rsp_valid_ff && rsp_status_ff != ST_DONE, rsp_word_ff == '0, "rejected response carries a word")

endmodule

// File: tb/sv/sequential_list_engine_tb.sv
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Streams list operations into the engine through the request channel and
// checks every response against a behavioural copy of the list kept in step
// with each accepted request. A short directed opening covers the empty list,
// the unused opcode, the end positions and the value extremes. Random phases
// then grow, shrink and mix the list, so that full, empty and out-of-range
// rejections recur, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sequential_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sle_pkg::*;

   localparam int CAPACITY = 16;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
   localparam int MAX_GAP = 14;
   localparam int LONG_HOLD = 250;
   localparam int HOLD_AT_RESPONSE = 300;
   localparam int RANDOM_REQUESTS = 1880;

   typedef enum int { PHASE_GROW, PHASE_SHRINK, PHASE_MIXED } phase_kind_type;

   typedef struct {
      logic [OPCODE_W-1:0]   opcode;
      logic [POSITION_W-1:0] position;
      logic [WORD_W-1:0]     value;
      int unsigned           lead_gap;
      bit                    wait_for_drain;
   } list_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic [WORD_W-1:0]   read_value;
   } list_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   list_request_type pending_requests[$];
   list_result_type  expected_results[$];
   int               total_requests;
   int               requests_accepted = 0;
   int               results_taken = 0;
   int               mismatch_count = 0;

   // Behavioural copy of the list contents.
   logic [WORD_W-1:0] list_words[CAPACITY];
   int                list_length = 0;

   sequential_list_engine #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic void open_slot(int pos, logic [WORD_W-1:0] word);
      for (int i = list_length; i > pos; i--) begin
         list_words[i] = list_words[i-1];
      end
      list_words[pos] = word;
      list_length++;
   endfunction

   function automatic void close_slot(int pos);
      for (int i = pos; i + 1 < list_length; i++) begin
         list_words[i] = list_words[i+1];
      end
      list_length--;
   endfunction

   // Applies one operation to the list copy and returns the response it gives.
   function automatic list_result_type apply_list_op(list_request_type rq);
      list_result_type rs;
      bit              full;
      bit              empty;
      int              pos;
      full  = list_length >= CAPACITY;
      empty = list_length == 0;
      pos   = int'(rq.position);
      rs.status     = ST_DONE;
      rs.read_value = '0;
      case (rq.opcode)
         OP_PUSH_BACK: begin
            if (full) rs.status = ST_FULL;
            else open_slot(list_length, rq.value);
         end
         OP_PUSH_FRONT: begin
            if (full) rs.status = ST_FULL;
            else open_slot(0, rq.value);
         end
         OP_POP_BACK: begin
            if (empty) rs.status = ST_EMPTY;
            else list_length--;
         end
         OP_POP_FRONT: begin
            if (empty) rs.status = ST_EMPTY;
            else close_slot(0);
         end
         OP_INSERT: begin
            if (full) rs.status = ST_FULL;
            else if (pos > list_length) rs.status = ST_RANGE;
            else open_slot(pos, rq.value);
         end
         OP_ERASE: begin
            if (empty) rs.status = ST_EMPTY;
            else if (pos >= list_length) rs.status = ST_RANGE;
            else close_slot(pos);
         end
         OP_READ: begin
            if (empty) rs.status = ST_EMPTY;
            else if (pos >= list_length) rs.status = ST_RANGE;
            else rs.read_value = list_words[pos];
         end
         default: begin
         end
      endcase
      rs.count = list_length[COUNT_W-1:0];
      return rs;
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                  logic [WORD_W-1:0] want);
      $display("%0t ns: response %0d, %s: got %0h, expected %0h",
               $realtime, results_taken, what, got, want);
      mismatch_count++;
   endtask

   function automatic int unsigned draw_gap(int index);
      // Every fourth stretch of items runs without any idling.
      if ((index / 128) % 4 == 1) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [WORD_W-1:0] draw_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POSITION_W-1:0] draw_position();
      if ($urandom_range(0, 4) == 0) return POSITION_W'($urandom_range(0, 31));
      return POSITION_W'($urandom_range(0, CAPACITY));
   endfunction

   function automatic logic [OPCODE_W-1:0] draw_opcode(phase_kind_type phase);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW: begin
            if (roll < 35) return OP_PUSH_BACK;
            if (roll < 65) return OP_PUSH_FRONT;
            if (roll < 85) return OP_INSERT;
            if (roll < 95) return OP_READ;
            return $urandom_range(0, 1) ? OP_UNUSED : OP_ERASE;
         end
         PHASE_SHRINK: begin
            if (roll < 30) return OP_POP_BACK;
            if (roll < 60) return OP_POP_FRONT;
            if (roll < 85) return OP_ERASE;
            if (roll < 95) return OP_READ;
            return $urandom_range(0, 1) ? OP_UNUSED : OP_INSERT;
         end
         default: return OPCODE_W'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic queue_request(logic [OPCODE_W-1:0] opcode, logic [POSITION_W-1:0] position,
                                logic [WORD_W-1:0] value, bit wait_for_drain);
      list_request_type rq;
      rq.opcode         = opcode;
      rq.position       = position;
      rq.value          = value;
      rq.lead_gap       = draw_gap(pending_requests.size());
      rq.wait_for_drain = wait_for_drain;
      pending_requests.push_back(rq);
   endtask

   // Request driver: waits out each item's lead gap, then offers it until taken.
   list_request_type offered;
   bit               offering = 1'b0;
   int unsigned      gap_left = 0;
   bit               gap_loaded = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_list_op(offered));
            requests_accepted++;
            offering = 1'b0;
         end
         if (!offering && pending_requests.size() > 0) begin
            if (!gap_loaded) begin
               gap_left   = pending_requests[0].lead_gap;
               gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else if (!pending_requests[0].wait_for_drain ||
                         results_taken == requests_accepted) begin
               offered    = pending_requests.pop_front();
               offering   = 1'b1;
               gap_loaded = 1'b0;
            end
         end
         req_tvalid <= offering;
         req_tdata  <= {offered.value, offered.position, offered.opcode};
      end
   end

   // Response monitor: checks each taken response and draws the next stall.
   int unsigned hold_left = 0;

   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status     = rsp_tdata[1:0];
            got.count      = rsp_tdata[6:2];
            got.read_value = rsp_tdata[38:7];
            if (expected_results.size() == 0) begin
               report_mismatch("response with no request outstanding", got.read_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
               if (got.count !== want.count)
                  report_mismatch("count", WORD_W'(got.count), WORD_W'(want.count));
               if (got.read_value !== want.read_value)
                  report_mismatch("read value", got.read_value, want.read_value);
            end
            if (rsp_tdata[39] !== 1'b0)
               report_mismatch("padding bit", WORD_W'(rsp_tdata[39]), '0);
            results_taken <= results_taken + 1;
            // One long hold-off lets the engine back up into the request side.
            if (results_taken == HOLD_AT_RESPONSE) hold_left = LONG_HOLD;
            else if ((results_taken / 128) % 4 == 3) hold_left = 0;
            else hold_left = $urandom_range(0, MAX_GAP);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_tready <= (hold_left == 0);
      end
   end

   initial begin
      phase_kind_type phase;
      int             phase_left;
      for (int i = 0; i < CAPACITY; i++) list_words[i] = '0;

      // Directed opening: empty list, unused opcode, end positions, extremes.
      queue_request(OP_READ,       5'd0,  draw_word(),    1'b0);
      queue_request(OP_POP_BACK,   5'd0,  draw_word(),    1'b0);
      queue_request(OP_POP_FRONT,  5'd0,  draw_word(),    1'b0);
      queue_request(OP_ERASE,      5'd0,  draw_word(),    1'b0);
      queue_request(OP_UNUSED,     5'd31, 32'hFFFF_FFFF,  1'b0);
      queue_request(OP_INSERT,     5'd1,  32'h1234_5678,  1'b0);
      queue_request(OP_INSERT,     5'd0,  32'h7FFF_FFFF,  1'b0);
      queue_request(OP_PUSH_BACK,  5'd31, 32'h8000_0000,  1'b0);
      queue_request(OP_PUSH_FRONT, 5'd17, 32'h0000_0000,  1'b0);
      queue_request(OP_INSERT,     5'd3,  32'h5555_5555,  1'b0);
      queue_request(OP_INSERT,     5'd2,  32'hAAAA_AAAA,  1'b0);
      queue_request(OP_READ,       5'd4,  32'hFFFF_FFFF,  1'b0);
      queue_request(OP_READ,       5'd5,  draw_word(),    1'b0);
      queue_request(OP_READ,       5'd31, draw_word(),    1'b0);
      queue_request(OP_ERASE,      5'd5,  draw_word(),    1'b0);
      queue_request(OP_ERASE,      5'd2,  draw_word(),    1'b0);
      queue_request(OP_READ,       5'd0,  draw_word(),    1'b0);
      queue_request(OP_POP_FRONT,  5'd16, draw_word(),    1'b0);
      queue_request(OP_POP_BACK,   5'd8,  draw_word(),    1'b0);
      queue_request(OP_UNUSED,     5'd16, 32'h0000_0000,  1'b0);
      queue_request(OP_ERASE,      5'd0,  draw_word(),    1'b0);
      queue_request(OP_READ,       5'd0,  draw_word(),    1'b0);
      queue_request(OP_POP_BACK,   5'd0,  draw_word(),    1'b0);

      // Random phases that fill, empty and churn the list.
      phase      = PHASE_GROW;
      phase_left = 40;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (phase_left == 0) begin
            case (phase)
               PHASE_GROW:   phase = PHASE_MIXED;
               PHASE_MIXED:  phase = $urandom_range(0, 1) ? PHASE_SHRINK : PHASE_GROW;
               default:      phase = PHASE_MIXED;
            endcase
            phase_left = (phase == PHASE_MIXED) ? 60 : 40;
         end
         phase_left--;
         // Twice in the run the sender holds back until the engine has drained.
         queue_request(draw_opcode(phase), draw_position(), draw_word(),
                       i == 500 || i == 1300);
      end
      total_requests = pending_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (requests_accepted == total_requests && expected_results.size() == 0);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sequential_list_engine_tb: PASS");
      end else begin
         $display("sequential_list_engine_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("sequential_list_engine_tb: FAIL");
      $finish;
   end

endmodule
